/* design/sibi_pkg.sv */
// Shared types and constants for the sorted interval box index.
package sibi_pkg;

   localparam int COORD_W = 32;
   localparam int ROW_W   = 32;

   typedef enum logic [1:0] {
      OP_INSERT   = 2'd0,
      OP_ERASE    = 2'd1,
      OP_SEARCH   = 2'd2,
      OP_RESERVED = 2'd3
   } op_type;

   typedef enum logic [1:0] {
      ST_OK        = 2'd0,
      ST_UNORDERED = 2'd1,
      ST_MISSING   = 2'd2,
      ST_FULL      = 2'd3
   } status_type;

   // What the back end is asked to do with a queued command.
   typedef enum logic [1:0] {
      K_INSERT = 2'd0,
      K_ERASE  = 2'd1,
      K_SEARCH = 2'd2,
      K_REPLY  = 2'd3
   } kind_type;

   typedef enum logic [2:0] {
      ENG_IDLE,
      ENG_INSERT,
      ENG_INS_HEAD,
      ENG_ERASE,
      ENG_SEARCH,
      ENG_REPLY
   } eng_state_type;

   typedef struct packed {
      op_type                     operation;
      logic signed [COORD_W-1:0]  box_min_x;
      logic signed [COORD_W-1:0]  box_min_y;
      logic signed [COORD_W-1:0]  box_max_x;
      logic signed [COORD_W-1:0]  box_max_y;
      logic        [ROW_W-1:0]    row_id;
   } req_type;

   typedef struct packed {
      status_type        status;
      logic              hit_valid;
      logic [ROW_W-1:0]  hit_row;
      logic              last;
   } rsp_type;

   typedef struct packed {
      logic signed [COORD_W-1:0]  min_x;
      logic signed [COORD_W-1:0]  min_y;
      logic signed [COORD_W-1:0]  max_x;
      logic signed [COORD_W-1:0]  max_y;
      logic        [ROW_W-1:0]    row;
   } entry_type;

   typedef struct packed {
      kind_type    kind;
      status_type  status;
      entry_type   box;
   } cmd_type;

endpackage

/* design/sorted_interval_box_index.sv */
// Top level of the sorted interval box index.
// Keeps up to CAPACITY boxes sorted by lower x in a single-port-write RAM and
// serves insert, erase and x-overlap search requests. Requests enter a
// two-beat command queue so the request side keeps moving while the back end
// works. The back end reads one table entry per cycle while the result side
// is not stalled, as the RAM offers one read and one write per cycle.
// Rejected, reserved and full-table requests go straight to the reply state.
// A search returns one beat per match with last on the final one, or a
// single empty beat.
module sorted_interval_box_index import sibi_pkg::*; #(
   parameter int CAPACITY = 64
) (
   input  logic     clock,
   input  logic     reset,
   input  logic     req_valid,
   output logic     req_stall,
   input  req_type  req_payload,
   output logic     rsp_valid,
   input  logic     rsp_stall,
   output rsp_type  rsp_payload
);

   logic     queue_full, push, pop, head_valid;
   cmd_type  push_cmd, head_cmd;

   sibi_front u_front (
      .req_valid   (req_valid),
      .req_payload (req_payload),
      .queue_full  (queue_full),
      .req_stall   (req_stall),
      .push        (push),
      .cmd         (push_cmd)
   );

   sibi_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_data  (push_cmd),
      .full       (queue_full),
      .pop        (pop),
      .head_valid (head_valid),
      .head       (head_cmd)
   );

   sibi_engine #(
      .CAPACITY (CAPACITY)
   ) u_engine (
      .clock       (clock),
      .reset       (reset),
      .cmd_valid   (head_valid),
      .cmd         (head_cmd),
      .cmd_pop     (pop),
      .rsp_valid   (rsp_valid),
      .rsp_payload (rsp_payload),
      .rsp_stall   (rsp_stall)
   );

endmodule

/* design/sibi_ram.sv */
// Generic simple dual-port RAM with one write port and a registered read port.
module sibi_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                                   clock,
   input  logic                                   wr_en,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                       wr_data,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                       rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write and registered read.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

/* design/sibi_front.sv */
// Front end: classifies each request beat into a back-end command.
module sibi_front import sibi_pkg::*; (
   input  logic     req_valid,
   input  req_type  req_payload,
   input  logic     queue_full,
   output logic     req_stall,
   output logic     push,
   output cmd_type  cmd
);

   logic unordered;

   // A box is rejected when either axis has its lower bound above its upper bound.
   assign unordered = (req_payload.box_min_x > req_payload.box_max_x) ||
                      (req_payload.box_min_y > req_payload.box_max_y);

   always_comb begin
      cmd.box.min_x = req_payload.box_min_x;
      cmd.box.min_y = req_payload.box_min_y;
      cmd.box.max_x = req_payload.box_max_x;
      cmd.box.max_y = req_payload.box_max_y;
      cmd.box.row   = req_payload.row_id;
      cmd.status    = ST_OK;
      cmd.kind      = K_REPLY;
      if (req_payload.operation == OP_RESERVED) begin
         cmd.kind = K_REPLY;
      end else if (unordered) begin
         cmd.status = ST_UNORDERED;
      end else begin
         case (req_payload.operation)
            OP_INSERT: cmd.kind = K_INSERT;
            OP_ERASE:  cmd.kind = K_ERASE;
            OP_SEARCH: cmd.kind = K_SEARCH;
            default:   cmd.kind = K_REPLY;
         endcase
      end
   end

   assign req_stall = queue_full;
   assign push      = req_valid && !queue_full;

endmodule

/* design/sibi_queue.sv */
// Two-entry command queue between the front end and the back end.
module sibi_queue import sibi_pkg::*; (
   input  logic     clock,
   input  logic     reset,
   input  logic     push,
   input  cmd_type  push_data,
   output logic     full,
   input  logic     pop,
   output logic     head_valid,
   output cmd_type  head
);

   cmd_type     slot_ff [2];
   logic        wr_ptr_ff, wr_ptr_in;
   logic        rd_ptr_ff, rd_ptr_in;
   logic [1:0]  count_ff, count_in;

   // Pointer and occupancy update.
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = !wr_ptr_ff;
      end
      if (pop) begin
         rd_ptr_in = !rd_ptr_ff;
      end
      if (push && !pop) begin
         count_in = count_ff + 2'd1;
      end else if (pop && !push) begin
         count_in = count_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Payload storage.
   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_data;
      end
   end

   assign full       = (count_ff == 2'd2);
   assign head_valid = (count_ff != 2'd0);
   assign head       = slot_ff[rd_ptr_ff];

endmodule

/* design/sibi_engine.sv */
// Back end: walks the sorted table in RAM to insert, erase and search entries.
module sibi_engine import sibi_pkg::*; #(
   parameter int CAPACITY = 64
) (
   input  logic     clock,
   input  logic     reset,
   input  logic     cmd_valid,
   input  cmd_type  cmd,
   output logic     cmd_pop,
   output logic     rsp_valid,
   output rsp_type  rsp_payload,
   input  logic     rsp_stall
);

   localparam int ADDR_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
   localparam int CNT_W  = $clog2(CAPACITY + 1);

   eng_state_type      state_ff, state_in;
   cmd_type            cmd_ff, cmd_in;
   logic [CNT_W-1:0]   fill_ff, fill_in;
   logic [ADDR_W-1:0]  ptr_ff, ptr_in;
   logic               found_ff, found_in;
   logic               pend_ff, pend_in;
   logic [ROW_W-1:0]   pend_row_ff, pend_row_in;
   status_type         status_ff, status_in;
   logic               rsp_valid_ff, rsp_valid_in;
   rsp_type            rsp_ff, rsp_in;

   logic               wr_en;
   logic [ADDR_W-1:0]  wr_addr, rd_addr;
   entry_type          wr_data, rd_entry;
   logic [$bits(entry_type)-1:0] rd_bits;
   logic               emit;
   rsp_type            emit_data;
   logic               out_free;
   logic [CNT_W-1:0]   fill_last;
   logic [ADDR_W-1:0]  last_idx;
   logic               at_last, is_match, is_hit, past_query;

   sibi_ram #(
      .WIDTH ($bits(entry_type)),
      .DEPTH (CAPACITY)
   ) u_table (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_addr (rd_addr),
      .rd_data (rd_bits)
   );

   assign rd_entry   = entry_type'(rd_bits);
   assign out_free   = !rsp_valid_ff || !rsp_stall;
   assign fill_last  = fill_ff - CNT_W'(1);
   assign last_idx   = fill_last[ADDR_W-1:0];
   assign at_last    = (ptr_ff == last_idx);
   assign is_match   = (rd_entry == cmd_ff.box);
   assign is_hit     = (rd_entry.max_x >= cmd_ff.box.min_x);
   assign past_query = (rd_entry.min_x > cmd_ff.box.max_x);

   // Sequencer: the entry read last cycle always belongs to ptr_ff.
   always_comb begin
      state_in    = state_ff;
      cmd_in      = cmd_ff;
      fill_in     = fill_ff;
      ptr_in      = ptr_ff;
      found_in    = found_ff;
      pend_in     = pend_ff;
      pend_row_in = pend_row_ff;
      status_in   = status_ff;
      cmd_pop     = 1'b0;
      rd_addr     = ptr_ff;
      wr_en       = 1'b0;
      wr_addr     = ptr_ff;
      wr_data     = rd_entry;
      emit        = 1'b0;
      emit_data   = '0;
      case (state_ff)
         ENG_IDLE: begin
            if (cmd_valid) begin
               cmd_pop   = 1'b1;
               cmd_in    = cmd;
               pend_in   = 1'b0;
               found_in  = 1'b0;
               status_in = ST_OK;
               ptr_in    = '0;
               rd_addr   = '0;
               state_in  = ENG_REPLY;
               case (cmd.kind)
                  K_INSERT: begin
                     if (fill_ff == CNT_W'(CAPACITY)) begin
                        status_in = ST_FULL;
                     end else if (fill_ff == '0) begin
                        wr_en   = 1'b1;
                        wr_addr = '0;
                        wr_data = cmd.box;
                        fill_in = CNT_W'(1);
                     end else begin
                        ptr_in   = last_idx;
                        rd_addr  = last_idx;
                        state_in = ENG_INSERT;
                     end
                  end
                  K_ERASE: begin
                     if (fill_ff == '0) begin
                        status_in = ST_MISSING;
                     end else begin
                        state_in = ENG_ERASE;
                     end
                  end
                  K_SEARCH: begin
                     if (fill_ff != '0) begin
                        state_in = ENG_SEARCH;
                     end
                  end
                  default: begin
                     status_in = cmd.status;
                  end
               endcase
            end
         end
         ENG_INSERT: begin
            // Walk down from the tail, moving larger keys up by one slot.
            wr_en   = 1'b1;
            wr_addr = ptr_ff + ADDR_W'(1);
            if (rd_entry.min_x > cmd_ff.box.min_x) begin
               wr_data = rd_entry;
               if (ptr_ff == '0) begin
                  state_in = ENG_INS_HEAD;
               end else begin
                  ptr_in  = ptr_ff - ADDR_W'(1);
                  rd_addr = ptr_ff - ADDR_W'(1);
               end
            end else begin
               wr_data  = cmd_ff.box;
               fill_in  = fill_ff + CNT_W'(1);
               state_in = ENG_REPLY;
            end
         end
         ENG_INS_HEAD: begin
            wr_en    = 1'b1;
            wr_addr  = '0;
            wr_data  = cmd_ff.box;
            fill_in  = fill_ff + CNT_W'(1);
            state_in = ENG_REPLY;
         end
         ENG_ERASE: begin
            // Find the first match, then close the gap behind it.
            if (found_ff) begin
               wr_en   = 1'b1;
               wr_addr = ptr_ff - ADDR_W'(1);
               wr_data = rd_entry;
            end else if (is_match) begin
               found_in = 1'b1;
            end
            if (at_last) begin
               if (found_ff || is_match) begin
                  fill_in = fill_last;
               end else begin
                  status_in = ST_MISSING;
               end
               state_in = ENG_REPLY;
            end else begin
               ptr_in  = ptr_ff + ADDR_W'(1);
               rd_addr = ptr_ff + ADDR_W'(1);
            end
         end
         ENG_SEARCH: begin
            // One hit is held back so that the final one can carry last.
            if (past_query) begin
               state_in = ENG_REPLY;
            end else if (is_hit && pend_ff && !out_free) begin
               rd_addr = ptr_ff;
            end else begin
               if (is_hit) begin
                  if (pend_ff) begin
                     emit              = 1'b1;
                     emit_data.status  = ST_OK;
                     emit_data.hit_valid = 1'b1;
                     emit_data.hit_row = pend_row_ff;
                     emit_data.last    = 1'b0;
                  end
                  pend_in     = 1'b1;
                  pend_row_in = rd_entry.row;
               end
               if (at_last) begin
                  state_in = ENG_REPLY;
               end else begin
                  ptr_in  = ptr_ff + ADDR_W'(1);
                  rd_addr = ptr_ff + ADDR_W'(1);
               end
            end
         end
         ENG_REPLY: begin
            if (out_free) begin
               emit                = 1'b1;
               emit_data.status    = status_ff;
               emit_data.hit_valid = pend_ff;
               emit_data.hit_row   = pend_ff ? pend_row_ff : '0;
               emit_data.last      = 1'b1;
               state_in            = ENG_IDLE;
            end
         end
         default: begin
            state_in = ENG_IDLE;
         end
      endcase
   end

   // Output register.
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_in       = rsp_ff;
      if (emit) begin
         rsp_valid_in = 1'b1;
         rsp_in       = emit_data;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ENG_IDLE;
         fill_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         fill_ff      <= fill_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff      <= cmd_in;
      ptr_ff      <= ptr_in;
      found_ff    <= found_in;
      pend_ff     <= pend_in;
      pend_row_ff <= pend_row_in;
      status_ff   <= status_in;
      rsp_ff      <= rsp_in;
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

endmodule

/* design/sibi_checker.sv */
// Port-level checks for the sorted interval box index, bound to the top level.
module sibi_checker import sibi_pkg::*; (
   input  logic     clock,
   input  logic     reset,
   input  logic     req_valid,
   input  logic     req_stall,
   input  logic     rsp_valid,
   input  logic     rsp_stall,
   input  rsp_type  rsp_payload
);

   logic [2:0] open_ff, open_in;
   logic       req_beat, done_beat;

   assign req_beat  = req_valid && !req_stall;
   assign done_beat = rsp_valid && !rsp_stall && rsp_payload.last;

   // Requests taken but not yet finished by a last beat.
   always_comb begin
      open_in = open_ff;
      if (req_beat && !done_beat) begin
         open_in = open_ff + 3'd1;
      end else if (done_beat && !req_beat) begin
         open_in = open_ff - 3'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         open_ff <= '0;
      end else begin
         open_ff <= open_in;
      end
   end

   a_stall_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_payload))
      else $error("result beat changed while stalled");

   a_no_orphan: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> open_ff != 3'd0)
      else $error("result beat with no request outstanding");

   // Two queued, one in the engine and one final beat waiting in the output register.
   a_bounded: assert property (@(posedge clock) disable iff (reset)
      open_ff <= 3'd4)
      else $error("more requests in flight than queue and engine hold");

   a_miss_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_payload.hit_valid |-> rsp_payload.last && rsp_payload.hit_row == '0)
      else $error("empty result beat is not the final beat");

endmodule

bind sorted_interval_box_index sibi_checker u_sibi_checker (
   .clock       (clock),
   .reset       (reset),
   .req_valid   (req_valid),
   .req_stall   (req_stall),
   .rsp_valid   (rsp_valid),
   .rsp_stall   (rsp_stall),
   .rsp_payload (rsp_payload)
);
